// File: src/assert_macros.svh
// Assertion macros shared by the particle pool RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked on every clock edge outside reset.
`define PPS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Property that must hold on every clock edge outside reset.
`define PPS_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
`else
`define PPS_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define PPS_ASSERT_ALWAYS(label, clk, rstn, cond, msg)
`endif
`endif

// File: src/pps_pkg.sv
// Shared types, constants and arithmetic helpers of the particle pool.
`default_nettype none
package pps_pkg;
    localparam int SlotCountDef = 16;
    localparam int MaxResults   = 16;

    localparam logic [2:0] CfgGravity  = 3'd0;
    localparam logic [2:0] CfgBuoyancy = 3'd1;
    localparam logic [2:0] CfgDamping  = 3'd2;
    localparam logic [2:0] CfgDefStep  = 3'd3;
    localparam logic [2:0] CfgMaxStep  = 3'd4;

    localparam logic OpTick  = 1'b0;
    localparam logic OpSpawn = 1'b1;

    localparam logic [2:0] KindCrumb = 3'd0;
    localparam logic [2:0] KindHeart = 3'd1;
    localparam logic [2:0] KindSleep = 3'd2;
    localparam logic [2:0] KindDirt  = 3'd3;

    localparam logic signed [23:0] PosMax = 24'sh7FFFFF;
    localparam logic signed [23:0] PosMin = -24'sh800000;

    // One queued request from the front to the back.
    typedef struct packed {
        logic        op;
        logic [15:0] dt;
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] vx;
        logic [23:0] vy;
        logic [2:0]  kind;
        logic [15:0] life;
    } req_t;

    // One result item.
    typedef struct packed {
        logic [5:0]  slot_index;
        logic        slot_alive;
        logic [2:0]  slot_kind;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic        spawn_ok;
        logic        is_last;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_VY, ST_DAMPX, ST_DAMPY, ST_POSX, ST_POSY,
        ST_WRITE, ST_EMIT, ST_SPAWN
    } back_state_t;

    // Saturate a 48-bit signed value to 24 bits.
    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        logic signed [23:0] r;
        if (v > 48'sd8388607) r = PosMax;
        else if (v < -48'sd8388608) r = PosMin;
        else r = v[23:0];
        return r;
    endfunction

    // Round half up and shift right by 16 (arithmetic).
    function automatic logic signed [47:0] rnd16(input logic signed [47:0] v);
        logic signed [47:0] t;
        t = v + 48'sd32768;
        return t >>> 16;
    endfunction

    // Truncate a 16.8 position toward zero to whole pixels.
    function automatic logic [15:0] to_pixel(input logic signed [23:0] p);
        logic signed [23:0] q;
        q = p >>> 8;
        if (p[23] && (p[7:0] != 8'd0)) q = q + 24'sd1;
        return q[15:0];
    endfunction
endpackage
`default_nettype wire

// File: src/pps_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module pps_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(Depth)-1:0] wr_addr,
    input  wire logic [Width-1:0]         wr_data,
    input  wire logic [$clog2(Depth)-1:0] rd_addr,
    output logic      [Width-1:0]         rd_data
);
    logic [Width-1:0] mem_reg [Depth];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wr_addr] <= wr_data;
        rd_data <= mem_reg[rd_addr];
    end
endmodule
`default_nettype wire

// File: src/pps_front.sv
// Front end: takes requests, validates the tick step and queues them.
`default_nettype none
module pps_front
    import pps_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire req_t        in_req,
    input  wire logic [15:0] default_step,
    input  wire logic [15:0] max_step,
    output logic             q_valid,
    input  wire logic        q_ready,
    output req_t             q_req
);
    localparam int QDepth = 2;

    req_t       slot_reg [QDepth];
    logic [1:0] count_reg, count_next;
    logic       wptr_reg, rptr_reg;
    req_t       fixed;
    logic       push, pop;

    // Replace an invalid tick step with the default one.
    always_comb begin
        fixed = in_req;
        if (in_req.dt == 16'd0 || in_req.dt > max_step) fixed.dt = default_step;
    end

    assign in_ready = (count_reg != 2'(QDepth));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_req    = slot_reg[rptr_reg];

    always_comb begin
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    // Two-entry queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
        end
        if (push) slot_reg[wptr_reg] <= fixed;
    end

`include "assert_macros.svh"
    `PPS_ASSERT_ALWAYS(a_cnt_range, aclk, aresetn, count_reg <= 2'(QDepth), "queue overflow")
    `PPS_ASSERT_IMP(a_no_push_full, aclk, aresetn, count_reg == 2'(QDepth), !push,
        "push into full queue")
    `PPS_ASSERT_IMP(a_dt_nonzero, aclk, aresetn, q_valid && !q_req.op && default_step != 16'd0,
        q_req.dt != 16'd0, "queued tick step is zero")
endmodule
`default_nettype wire

// File: src/pps_back.sv
// Back end: spawns particles and steps every slot through a shared multiplier.
`default_nettype none
module pps_back
    import pps_pkg::*;
#(
    parameter int SlotCount = SlotCountDef
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire req_t        q_req,
    input  wire logic [15:0] gravity_accel,
    input  wire logic [15:0] buoyancy_accel,
    input  wire logic [15:0] damping_factor,
    output logic             res_valid,
    input  wire logic        res_ready,
    output res_t             res_data
);
    localparam int IdxW    = (SlotCount > 1) ? $clog2(SlotCount) : 1;
    localparam int NReport = (SlotCount < MaxResults) ? SlotCount : MaxResults;
    localparam int RecW    = 24 * 4 + 3 + 16 + 16;

    back_state_t state_reg, state_next;
    logic [SlotCount-1:0] alive_reg;
    logic [IdxW-1:0]   idx_reg;
    req_t              req_reg;
    logic signed [23:0] px_reg, py_reg, vx_reg, vy_reg;
    logic [2:0]        kind_reg;
    logic [15:0]       age_reg, life_reg;
    logic              was_live_reg, still_reg;
    logic signed [47:0] prod_reg;
    res_t              out_reg;
    logic              out_valid_reg;

    logic [RecW-1:0]   wr_rec, rd_rec;
    logic              wr_en;
    logic [IdxW-1:0]   wr_addr;
    logic [IdxW-1:0]   free_idx;
    logic              free_found;
    logic signed [16:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [47:0] mul_p;
    logic [16:0]       age_sum;
    logic [15:0]       age_new;
    logic              emit_ok;
    logic [2:0]        rd_kind;
    logic signed [23:0] py_new;
    logic              report_slot;
    logic              out_load;

    pps_ram #(.Width(RecW), .Depth(SlotCount)) u_ram (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_rec),
        .rd_addr(idx_reg), .rd_data(rd_rec)
    );

    // Kind of the slot being read, straight from the RAM output.
    assign rd_kind = rd_rec[34:32];

    // Lowest free slot.
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = SlotCount - 1; i >= 0; i--) begin
            if (!alive_reg[i]) begin
                free_idx   = IdxW'(i);
                free_found = 1'b1;
            end
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_VY: begin
                mul_b = 25'(signed'({1'b0, req_reg.dt}));
                case (rd_kind)
                    KindCrumb, KindDirt: mul_a = 17'(signed'(gravity_accel));
                    KindHeart, KindSleep: mul_a = 17'(signed'(buoyancy_accel));
                    default: mul_a = '0;
                endcase
            end
            ST_DAMPX: begin
                mul_a = 17'(signed'({1'b0, damping_factor}));
                mul_b = 25'(vx_reg);
            end
            ST_DAMPY: begin
                mul_a = 17'(signed'({1'b0, damping_factor}));
                mul_b = 25'(vy_reg);
            end
            ST_POSX: begin
                mul_a = 17'(signed'({1'b0, req_reg.dt}));
                mul_b = 25'(vx_reg);
            end
            ST_POSY: begin
                mul_a = 17'(signed'({1'b0, req_reg.dt}));
                mul_b = 25'(vy_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 48'(mul_a) * 48'(mul_b);
    end

    assign age_sum = {1'b0, age_reg} + 17'((20'(req_reg.dt) + 20'd8) >> 4);
    assign age_new = age_sum[16] ? 16'hFFFF : age_sum[15:0];
    assign py_new  = sat24(48'(py_reg) + rnd16(prod_reg));
    assign emit_ok = !out_valid_reg || res_ready;
    assign report_slot = (32'(idx_reg) < NReport);
    assign out_load = (state_reg == ST_SPAWN && emit_ok)
                      || (state_reg == ST_EMIT && emit_ok && report_slot);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (q_valid) state_next = q_req.op ? ST_SPAWN : ST_LOAD;
            ST_SPAWN: if (emit_ok) state_next = ST_IDLE;
            ST_LOAD:  state_next = ST_VY;
            ST_VY:    state_next = ST_DAMPX;
            ST_DAMPX: state_next = ST_DAMPY;
            ST_DAMPY: state_next = ST_POSX;
            ST_POSX:  state_next = ST_POSY;
            ST_POSY:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_EMIT;
            ST_EMIT: begin
                if (emit_ok || !report_slot) begin
                    state_next = (idx_reg == IdxW'(SlotCount - 1)) ? ST_IDLE : ST_LOAD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        q_ready = (state_reg == ST_IDLE);
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_rec  = {px_reg, py_reg, vx_reg, vy_reg, kind_reg, age_reg, life_reg};
        case (state_reg)
            ST_SPAWN: begin
                wr_en   = emit_ok && free_found;
                wr_addr = free_idx;
                wr_rec  = {req_reg.x, req_reg.y, req_reg.vx, req_reg.vy, req_reg.kind,
                           16'd0, req_reg.life};
            end
            ST_WRITE: begin
                wr_en  = was_live_reg;
                wr_rec = {px_reg, py_new, vx_reg, vy_reg, kind_reg, age_new, life_reg};
            end
            default: wr_en = 1'b0;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        case (state_reg)
            ST_IDLE: if (q_valid) begin
                req_reg <= q_req;
                idx_reg <= '0;
            end
            ST_LOAD: was_live_reg <= alive_reg[idx_reg];
            ST_VY: begin
                {px_reg, py_reg, vx_reg, vy_reg, kind_reg, age_reg, life_reg} <= rd_rec;
            end
            ST_DAMPX: begin
                if (kind_reg == KindDirt)
                    vy_reg <= sat24(48'(vy_reg) + ((prod_reg + 48'sd65536) >>> 17));
                else if (kind_reg == KindCrumb || kind_reg == KindHeart
                         || kind_reg == KindSleep)
                    vy_reg <= sat24(48'(vy_reg) + rnd16(prod_reg));
            end
            ST_DAMPY: vx_reg <= sat24(rnd16(prod_reg));
            ST_POSX: vy_reg <= sat24(rnd16(prod_reg));
            ST_POSY: px_reg <= sat24(48'(px_reg) + rnd16(prod_reg));
            ST_WRITE: begin
                py_reg   <= py_new;
                age_reg  <= age_new;
                still_reg <= (age_new < life_reg);
            end
            ST_EMIT: if (emit_ok || !report_slot) idx_reg <= idx_reg + 1'b1;
            default: ;
        endcase
    end

    // Alive flags, result register and state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            alive_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) out_valid_reg <= 1'b1;
            else if (res_ready) out_valid_reg <= 1'b0;
            if (state_reg == ST_SPAWN && emit_ok) begin
                if (free_found) begin
                    alive_reg[free_idx] <= 1'b1;
                    out_reg <= '{6'(free_idx), 1'b1, req_reg.kind, to_pixel(req_reg.x),
                                 to_pixel(req_reg.y), 1'b1, 1'b1};
                end else begin
                    out_reg <= '{6'd0, 1'b0, 3'd0, 16'd0, 16'd0, 1'b0, 1'b1};
                end
            end
            if (state_reg == ST_WRITE && was_live_reg && (age_new >= life_reg))
                alive_reg[idx_reg] <= 1'b0;
            if (state_reg == ST_EMIT && emit_ok && report_slot) begin
                if (was_live_reg)
                    out_reg <= '{6'(idx_reg), still_reg, kind_reg, to_pixel(px_reg),
                                 to_pixel(py_reg), 1'b0,
                                 (idx_reg == IdxW'(NReport - 1))};
                else
                    out_reg <= '{6'(idx_reg), 1'b0, 3'd0, 16'd0, 16'd0, 1'b0,
                                 (idx_reg == IdxW'(NReport - 1))};
            end
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

`include "assert_macros.svh"
    `PPS_ASSERT_IMP(a_spawn_alive, aclk, aresetn,
        state_reg == ST_SPAWN && emit_ok && free_found, ##1 alive_reg[$past(free_idx)],
        "spawned slot not marked live")
    `PPS_ASSERT_IMP(a_out_hold, aclk, aresetn, out_valid_reg && !res_ready,
        ##1 (out_valid_reg && $stable(out_reg)), "pending result changed")
    `PPS_ASSERT_IMP(a_busy_no_take, aclk, aresetn, state_reg != ST_IDLE, !q_ready,
        "queue popped while busy")
endmodule
`default_nettype wire

// File: src/particle_pool_step_unit.sv
// Top level of the particle pool: config registers, front queue and back sequencer.
// Usage:
// Requests arrive on the s_axis stream: tuser carries the operation (0 tick, 1 spawn)
// and tdata the packed tick step and spawn fields. Results leave on m_axis, one item
// per spawn and one per reported slot on a tick, tlast marking the final result.
// A spawn takes the lowest free slot; a tick steps each slot in turn through load,
// five uses of the single shared multiplier, write-back and report. A two-entry queue
// sits between the front and the sequencer so requests are taken while a tick runs.
// Reset (aresetn low, synchronous) restores the register defaults, empties the queue
// and marks every slot free. A stalled m_axis holds the result register and the
// sequencer waits; the queue keeps taking requests until full.
// Configuration writes through cfg_wr_en/cfg_index/cfg_data only while idle.
`default_nettype none
module particle_pool_step_unit
    import pps_pkg::*;
#(
    parameter int SlotCount = SlotCountDef
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: time_step[15:0], spawn_x, spawn_y, spawn_vx, spawn_vy, spawn_kind,
    // spawn_life, zero fill to 136 bits
    input  wire logic [135:0] s_axis_tdata,
    // tuser: operation
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: slot_index, slot_alive, slot_kind, pixel_x, pixel_y, zero fill to 48 bits
    output logic [47:0]       m_axis_tdata,
    // tuser: spawn_ok
    output logic              m_axis_tuser,
    output logic              m_axis_tlast
);
    logic [15:0] grav_reg, buoy_reg, damp_reg, defstep_reg, maxstep_reg;
    req_t  in_req, q_req;
    logic  q_valid, q_ready;
    res_t  res;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg    <= 16'd5120;
            buoy_reg    <= 16'hF100;
            damp_reg    <= 16'd64225;
            defstep_reg <= 16'd1094;
            maxstep_reg <= 16'd32768;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CfgGravity:  grav_reg    <= cfg_data;
                CfgBuoyancy: buoy_reg    <= cfg_data;
                CfgDamping:  damp_reg    <= cfg_data;
                CfgDefStep:  defstep_reg <= cfg_data;
                CfgMaxStep:  maxstep_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the request.
    always_comb begin
        in_req.op   = s_axis_tuser;
        in_req.dt   = s_axis_tdata[15:0];
        in_req.x    = s_axis_tdata[39:16];
        in_req.y    = s_axis_tdata[63:40];
        in_req.vx   = s_axis_tdata[87:64];
        in_req.vy   = s_axis_tdata[111:88];
        in_req.kind = s_axis_tdata[114:112];
        in_req.life = s_axis_tdata[130:115];
    end

    pps_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_req(in_req), .default_step(defstep_reg), .max_step(maxstep_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    pps_back #(.SlotCount(SlotCount)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_req(q_req), .gravity_accel(grav_reg), .buoyancy_accel(buoy_reg),
        .damping_factor(damp_reg), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .res_data(res)
    );

    assign m_axis_tdata = {6'd0, res.pixel_y, res.pixel_x, res.slot_kind,
                           res.slot_alive, res.slot_index};
    assign m_axis_tuser = res.spawn_ok;
    assign m_axis_tlast = res.is_last;
endmodule
`default_nettype wire
